// ===== rtl/lic_pkg.sv =====
package lic_pkg;

   localparam int QBITS = 33;
   localparam int REM_W = 64 + QBITS;

   localparam logic [QBITS-1:0] POS_LIMIT = 33'h07FFFFFFF;
   localparam logic [QBITS-1:0] NEG_LIMIT = 33'h080000000;

   typedef struct packed {
      logic signed [31:0] a_x_coeff;
      logic signed [31:0] a_y_coeff;
      logic signed [31:0] a_offset;
      logic signed [31:0] b_x_coeff;
      logic signed [31:0] b_y_coeff;
      logic signed [31:0] b_offset;
   } req_type;

   typedef struct packed {
      logic signed [31:0] point_x;
      logic signed [31:0] point_y;
      logic               is_parallel;
      logic               overflowed;
   } rsp_type;

   typedef struct packed {
      logic valid;
      logic par;
      logic neg_x;
      logic neg_y;
      logic sat_x;
      logic sat_y;
   } ctl_type;

endpackage

// ===== rtl/lic_front.sv =====
module lic_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             en,
   input  logic             in_valid,
   input  lic_pkg::req_type in_req,
   output logic             out_valid,
   output logic             out_par,
   output logic             out_neg_x,
   output logic             out_neg_y,
   output logic [63:0]      out_num_x,
   output logic [63:0]      out_num_y,
   output logic [63:0]      out_den
);

   logic               v1_ff;
   logic signed [63:0] p_a1b2_ff, p_a2b1_ff, p_c2b1_ff, p_c1b2_ff, p_a2c1_ff, p_a1c2_ff;
   logic               v2_ff;
   logic               par_ff, neg_x_ff, neg_y_ff;
   logic [63:0]        num_x_ff, num_y_ff, den_ff;

   logic signed [63:0] det_in, nx_in, ny_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p_a1b2_ff <= 64'(in_req.a_x_coeff) * 64'(in_req.b_y_coeff);
         p_a2b1_ff <= 64'(in_req.b_x_coeff) * 64'(in_req.a_y_coeff);
         p_c2b1_ff <= 64'(in_req.b_offset)  * 64'(in_req.a_y_coeff);
         p_c1b2_ff <= 64'(in_req.a_offset)  * 64'(in_req.b_y_coeff);
         p_a2c1_ff <= 64'(in_req.b_x_coeff) * 64'(in_req.a_offset);
         p_a1c2_ff <= 64'(in_req.a_x_coeff) * 64'(in_req.b_offset);
      end
   end

   always_comb begin
      det_in = p_a1b2_ff - p_a2b1_ff;
      nx_in  = p_c2b1_ff - p_c1b2_ff;
      ny_in  = p_a2c1_ff - p_a1c2_ff;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         par_ff   <= (det_in == 64'sd0);
         neg_x_ff <= nx_in[63] != det_in[63];
         neg_y_ff <= ny_in[63] != det_in[63];
         num_x_ff <= nx_in[63]  ? 64'(-nx_in)  : 64'(nx_in);
         num_y_ff <= ny_in[63]  ? 64'(-ny_in)  : 64'(ny_in);
         den_ff   <= det_in[63] ? 64'(-det_in) : 64'(det_in);
      end
   end

   assign out_valid = v2_ff;
   assign out_par   = par_ff;
   assign out_neg_x = neg_x_ff;
   assign out_neg_y = neg_y_ff;
   assign out_num_x = num_x_ff;
   assign out_num_y = num_y_ff;
   assign out_den   = den_ff;

endmodule

// ===== rtl/lic_cell.sv =====
module lic_cell #(
   parameter int SHIFT = 0
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      en,
   input  lic_pkg::ctl_type          ctl_in,
   input  logic [lic_pkg::REM_W-1:0] rem_x_in,
   input  logic [lic_pkg::REM_W-1:0] rem_y_in,
   input  logic [63:0]               den_in,
   input  logic [lic_pkg::QBITS-1:0] q_x_in,
   input  logic [lic_pkg::QBITS-1:0] q_y_in,
   output lic_pkg::ctl_type          ctl_ff,
   output logic [lic_pkg::REM_W-1:0] rem_x_ff,
   output logic [lic_pkg::REM_W-1:0] rem_y_ff,
   output logic [63:0]               den_ff,
   output logic [lic_pkg::QBITS-1:0] q_x_ff,
   output logic [lic_pkg::QBITS-1:0] q_y_ff
);

   logic [lic_pkg::REM_W-1:0] trial;
   logic                      ge_x, ge_y;

   always_comb begin
      trial = lic_pkg::REM_W'(den_in) << SHIFT;
      ge_x  = rem_x_in >= trial;
      ge_y  = rem_y_in >= trial;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else if (en) begin
         ctl_ff <= ctl_in;
      end
   end

   // one quotient bit per cell for each coordinate
   always_ff @(posedge clock) begin
      if (en) begin
         rem_x_ff <= ge_x ? rem_x_in - trial : rem_x_in;
         rem_y_ff <= ge_y ? rem_y_in - trial : rem_y_in;
         den_ff   <= den_in;
         q_x_ff   <= {q_x_in[lic_pkg::QBITS-2:0], ge_x};
         q_y_ff   <= {q_y_in[lic_pkg::QBITS-2:0], ge_y};
      end
   end

endmodule

// ===== rtl/line_intersection_cramer_unit.sv =====
// Intersection of two lines a*x+b*y+c=0 by Cramer's rule, signed fixed point with
// FRAC_BITS fraction bits. Fully pipelined: one request per cycle while not stalled.
// Stages: input, products, differences, range check, 33 restoring-divide cells,
// output; each divide cell yields one quotient bit. Parallel lines return the
// sentinel 32767.0; out-of-range quotients saturate and set overflowed. A stalled
// result holds the whole pipeline.
module line_intersection_cramer_unit #(
   parameter int FRAC_BITS = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  lic_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output lic_pkg::rsp_type rsp_data
);

   localparam int QB = lic_pkg::QBITS;
   localparam int RW = lic_pkg::REM_W;
   localparam logic [47:0] SENT_WIDE = 48'(32767) << FRAC_BITS;
   localparam logic [31:0] SENTINEL  = (FRAC_BITS > 16) ? 32'h7FFFFFFF : SENT_WIDE[31:0];

   logic             en;
   logic             in_valid_ff;
   lic_pkg::req_type in_req_ff;

   logic             f_valid, f_par, f_neg_x, f_neg_y;
   logic [63:0]      f_num_x, f_num_y, f_den;

   lic_pkg::ctl_type ctl_c   [0:QB];
   logic [RW-1:0]    rem_x_c [0:QB];
   logic [RW-1:0]    rem_y_c [0:QB];
   logic [63:0]      den_c   [0:QB];
   logic [QB-1:0]    q_x_c   [0:QB];
   logic [QB-1:0]    q_y_c   [0:QB];

   logic [RW-1:0]    dvd_x_in, dvd_y_in, top_in;

   logic             rsp_valid_ff;
   lic_pkg::rsp_type rsp_ff, rsp_in;

   logic [QB-1:0]    lim_x, lim_y, mag_x, mag_y;
   logic             ovf_x, ovf_y;

   assign en        = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !en;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (en) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         in_req_ff <= req_data;
      end
   end

   lic_front u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (in_valid_ff),
      .in_req    (in_req_ff),
      .out_valid (f_valid),
      .out_par   (f_par),
      .out_neg_x (f_neg_x),
      .out_neg_y (f_neg_y),
      .out_num_x (f_num_x),
      .out_num_y (f_num_y),
      .out_den   (f_den)
   );

   // flag quotients of 2^33 or more before the divide chain
   always_comb begin
      dvd_x_in = RW'(f_num_x) << FRAC_BITS;
      dvd_y_in = RW'(f_num_y) << FRAC_BITS;
      top_in   = RW'(f_den) << QB;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_c[0] <= '0;
      end else if (en) begin
         ctl_c[0].valid <= f_valid;
         ctl_c[0].par   <= f_par;
         ctl_c[0].neg_x <= f_neg_x;
         ctl_c[0].neg_y <= f_neg_y;
         ctl_c[0].sat_x <= dvd_x_in >= top_in;
         ctl_c[0].sat_y <= dvd_y_in >= top_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_x_c[0] <= dvd_x_in;
         rem_y_c[0] <= dvd_y_in;
         den_c[0]   <= f_den;
         q_x_c[0]   <= '0;
         q_y_c[0]   <= '0;
      end
   end

   for (genvar i = 0; i < QB; i++) begin : g_cell
      lic_cell #(
         .SHIFT (QB - 1 - i)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .en       (en),
         .ctl_in   (ctl_c[i]),
         .rem_x_in (rem_x_c[i]),
         .rem_y_in (rem_y_c[i]),
         .den_in   (den_c[i]),
         .q_x_in   (q_x_c[i]),
         .q_y_in   (q_y_c[i]),
         .ctl_ff   (ctl_c[i+1]),
         .rem_x_ff (rem_x_c[i+1]),
         .rem_y_ff (rem_y_c[i+1]),
         .den_ff   (den_c[i+1]),
         .q_x_ff   (q_x_c[i+1]),
         .q_y_ff   (q_y_c[i+1])
      );
   end

   // apply sign, saturate, substitute the sentinel for parallel lines
   always_comb begin
      lim_x = ctl_c[QB].neg_x ? lic_pkg::NEG_LIMIT : lic_pkg::POS_LIMIT;
      lim_y = ctl_c[QB].neg_y ? lic_pkg::NEG_LIMIT : lic_pkg::POS_LIMIT;
      ovf_x = ctl_c[QB].sat_x || (q_x_c[QB] > lim_x);
      ovf_y = ctl_c[QB].sat_y || (q_y_c[QB] > lim_y);
      mag_x = ovf_x ? lim_x : q_x_c[QB];
      mag_y = ovf_y ? lim_y : q_y_c[QB];
      if (ctl_c[QB].par) begin
         rsp_in.point_x     = SENTINEL;
         rsp_in.point_y     = SENTINEL;
         rsp_in.is_parallel = 1'b1;
         rsp_in.overflowed  = 1'b0;
      end else begin
         rsp_in.point_x     = ctl_c[QB].neg_x ? 32'(-mag_x) : mag_x[31:0];
         rsp_in.point_y     = ctl_c[QB].neg_y ? 32'(-mag_y) : mag_y[31:0];
         rsp_in.is_parallel = 1'b0;
         rsp_in.overflowed  = ovf_x || ovf_y;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= ctl_c[QB].valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
